/* design/ucp_pkg.sv */
// Shared types, character codes and the direction table of the drive command parser.
package ucp_pkg;

  localparam int unsigned ADDR_LEN_DEF = 15;

  localparam logic [7:0] CH_START = 8'h5E;  // '^'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_R     = 8'h72;  // 'r'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_O     = 8'h6F;  // 'o'

  localparam logic [3:0] DIR_NONE = 4'd13;

  typedef enum logic [2:0] {
    PS_IDLE  = 3'd0,
    PS_F1    = 3'd1,
    PS_F2    = 3'd2,
    PS_F3    = 3'd3,
    PS_F4    = 3'd4,
    PS_DIR   = 3'd5,
    PS_DIGIT = 3'd6
  } ucp_state_t;

  // Command side of one result item, values after the byte's update.
  typedef struct packed {
    logic       done;
    logic [3:0] dir;
    logic [4:0] dur;
    logic [7:0] cnt;
  } ucp_cmd_t;

  // Address capture side of one result item.
  typedef struct packed {
    logic       written;
    logic [3:0] slot;
    logic       active;
  } ucp_cap_t;

  // Dense direction code of a letter, or DIR_NONE for anything else.
  function automatic logic [3:0] letter_code(input logic [7:0] b);
    logic [3:0] code;
    unique case (b)
      8'h46:   code = 4'd0;   // F
      8'h42:   code = 4'd1;   // B
      8'h4C:   code = 4'd2;   // L
      8'h52:   code = 4'd3;   // R
      8'h43:   code = 4'd4;   // C
      8'h4F:   code = 4'd5;   // O
      8'h54:   code = 4'd6;   // T
      8'h48:   code = 4'd7;   // H
      8'h50:   code = 4'd8;   // P
      8'h4B:   code = 4'd9;   // K
      8'h4D:   code = 4'd10;  // M
      8'h4E:   code = 4'd11;  // N
      8'h5A:   code = 4'd12;  // Z
      default: code = DIR_NONE;
    endcase
    return code;
  endfunction

endpackage

/* design/ucp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ucp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/ucp_parser.sv */
// Command frame recogniser: parse state, direction, duration and command counter.
module ucp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        rx_byte,
  output ucp_pkg::ucp_cmd_t cmd
);
  import ucp_pkg::*;

  ucp_state_t state_r, state_nxt;
  logic [3:0] dir_r, dir_nxt;
  logic [4:0] dur_r, dur_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       done;
  logic [3:0] code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_IDLE;
      dir_r   <= DIR_NONE;
      dur_r   <= '0;
      cnt_r   <= '0;
    end else if (en) begin
      state_r <= state_nxt;
      dir_r   <= dir_nxt;
      dur_r   <= dur_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dir_nxt   = dir_r;
    dur_nxt   = dur_r;
    cnt_nxt   = cnt_r;
    done      = 1'b0;
    code      = letter_code(rx_byte);
    if (rx_byte == CH_START) begin
      state_nxt = PS_F1;
    end else begin
      unique case (state_r)
        PS_F1, PS_F2, PS_F3, PS_F4: begin
          // Frame digits '1' to '4' follow the state number.
          if (rx_byte == CH_ZERO + 8'(state_r)) begin
            state_nxt = ucp_state_t'(state_r + 3'd1);
          end
        end
        PS_DIR: begin
          if (code != DIR_NONE) begin
            dir_nxt   = code;
            state_nxt = PS_DIGIT;
          end
        end
        PS_DIGIT: begin
          if (rx_byte > CH_ZERO && rx_byte < CH_NINE) begin
            // Low nibble of '1'..'8' is the digit itself.
            dur_nxt   = 5'(rx_byte[3:0]) * 5'd3;
            cnt_nxt   = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;
            state_nxt = PS_IDLE;
            done      = 1'b1;
          end
        end
        default: state_nxt = state_r;
      endcase
    end
  end

  assign cmd.done = done;
  assign cmd.dir  = dir_nxt;
  assign cmd.dur  = dur_nxt;
  assign cmd.cnt  = cnt_nxt;

endmodule

/* design/ucp_capture.sv */
// Address capture: 'r=' marker detection, store fill count and the address store.
module ucp_capture #(
  parameter int unsigned ADDR_LEN = ucp_pkg::ADDR_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        rx_byte,
  output ucp_pkg::ucp_cap_t cap
);
  import ucp_pkg::*;

  localparam int unsigned CW = $clog2(ADDR_LEN + 1);
  localparam int unsigned AW = (ADDR_LEN > 1) ? $clog2(ADDR_LEN) : 1;

  logic [7:0]    prev_r, prev2_r;
  logic          flag_r, flag_nxt;
  logic [CW-1:0] cnt_r;
  logic          wr;

  assign flag_nxt = flag_r || (prev2_r == CH_R && prev_r == CH_EQ);
  assign wr       = flag_nxt && (cnt_r < CW'(ADDR_LEN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= CH_O;
      prev2_r <= CH_O;
      flag_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (en) begin
      prev_r  <= rx_byte;
      prev2_r <= prev_r;
      flag_r  <= flag_nxt;
      if (wr) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  ucp_ram #(
    .WIDTH (8),
    .DEPTH (ADDR_LEN),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (en && wr),
    .wr_addr (AW'(cnt_r)),
    .wr_data (rx_byte),
    .rd_addr ('0),
    .rd_data ()
  );

  assign cap.written = wr;
  assign cap.slot    = wr ? 4'(cnt_r) : 4'd0;
  assign cap.active  = flag_nxt;

endmodule

/* design/uart_drive_command_parser_top.sv */
// Top level of the drive command parser: input register, parse logic and result register.
//
//  channel | dir | ports                              | item
//  --------+-----+------------------------------------+---------------------------------
//  in      | in  | in_tvalid, in_tready, in_tdata[7:0] | one received byte
//  out     | out | out_tvalid, out_tready, out_tdata   | echo plus command/capture status
//
// Each accepted byte is held in the input register, then passes through the parse and
// capture logic into the result register. A byte is accepted in every cycle while the
// result side keeps taking items. Reset (rst_n low, synchronous) empties both registers
// and returns the parser and capture state to idle. A stall on the result side holds the
// result and, once the input register is full, lowers in_tready.
module uart_drive_command_parser_top #(
  parameter int unsigned ADDR_LEN = ucp_pkg::ADDR_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] echo_byte, [8] command_done, [12:9] direction_code, [17:13] duration_units,
  // [25:18] command_count, [26] addr_written, [30:27] addr_slot, [31] capture_active
  output logic [31:0] out_tdata
);
  import ucp_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic [31:0] out_data_r, out_data_nxt;
  logic       out_free;
  logic       step;
  ucp_cmd_t   cmd;
  ucp_cap_t   cap;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  ucp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (step),
    .rx_byte (in_byte_r),
    .cmd     (cmd)
  );

  ucp_capture #(
    .ADDR_LEN (ADDR_LEN)
  ) u_capture (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (step),
    .rx_byte (in_byte_r),
    .cap     (cap)
  );

  assign out_data_nxt = {cap.active, cap.slot, cap.written, cmd.cnt, cmd.dur, cmd.dir,
                         cmd.done, in_byte_r};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/ucp_checker.sv */
// Port-level checker for the drive command parser, bound to the top level.
module ucp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic       acc;
  logic [7:0] last_cnt_r;
  logic       seen_active_r;

  assign acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r    <= '0;
      seen_active_r <= 1'b0;
    end else if (acc) begin
      last_cnt_r    <= out_tdata[25:18];
      seen_active_r <= seen_active_r || out_tdata[31];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    acc && out_tdata[8] |-> out_tdata[12:9] != 4'd13 && out_tdata[17:13] >= 5'd3
      && out_tdata[17:13] <= 5'd24)
    else $error("completed command without direction or with bad duration");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (out_tdata[8] && last_cnt_r != 8'hFF) ? out_tdata[25:18] == last_cnt_r + 8'd1
                                                  : out_tdata[25:18] == last_cnt_r)
    else $error("command counter stepped wrongly");

  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (!out_tdata[26] || out_tdata[31]) && (!seen_active_r || out_tdata[31]))
    else $error("capture flag dropped or store written before the marker");

endmodule

bind uart_drive_command_parser_top ucp_checker u_ucp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/sv/tb.sv */
// Self-checking testbench of the drive command parser: stream stimulus, prediction and checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucp_pkg::*;

  localparam int ADDR_LEN    = ADDR_LEN_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int RANDOM_ITEMS = 450;
  // Direction letters in code order, F first in the top byte.
  localparam logic [13*8-1:0] DIR_LETTERS = "FBLRCOTHPKMNZ";

  typedef struct packed {
    logic       capture_active;
    logic [3:0] addr_slot;
    logic       addr_written;
    logic [7:0] command_count;
    logic [4:0] duration_units;
    logic [3:0] direction_code;
    logic       command_done;
    logic [7:0] echo_byte;
  } drive_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;     // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] echo_byte, [8] command_done, [12:9] direction_code, [17:13] duration_units,
  // [25:18] command_count, [26] addr_written, [30:27] addr_slot, [31] capture_active
  logic [31:0] out_tdata;

  // Model state of the parser.
  ucp_state_t  cmd_state = PS_IDLE;
  logic [3:0]  dir_latched = DIR_NONE;
  logic [4:0]  dur_latched = 5'd0;
  logic [7:0]  cmd_count = 8'd0;
  logic [7:0]  last_byte = CH_O;
  logic [7:0]  last2_byte = CH_O;
  logic        capture_on = 1'b0;
  int          stored_count = 0;

  drive_status_t echo_status_q[$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  logic hold_long = 1'b0;
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet = 0;

  uart_drive_command_parser_top #(.ADDR_LEN(ADDR_LEN)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [3:0] dir_code_of(input logic [7:0] b);
    for (int i = 0; i < 13; i++) begin
      if (b == DIR_LETTERS[(12 - i) * 8 +: 8]) return 4'(i);
    end
    return DIR_NONE;
  endfunction

  // Advances the model by one received byte and returns the status it produces.
  function automatic drive_status_t parse_byte(input logic [7:0] b);
    drive_status_t r;
    logic [3:0] code;
    r = '0;
    r.echo_byte = b;
    if (b == CH_START) begin
      cmd_state = PS_F1;
    end else begin
      case (cmd_state)
        PS_F1, PS_F2, PS_F3, PS_F4: begin
          if (b == CH_ZERO + 8'(cmd_state)) cmd_state = ucp_state_t'(cmd_state + 3'd1);
        end
        PS_DIR: begin
          code = dir_code_of(b);
          if (code != DIR_NONE) begin
            dir_latched = code;
            cmd_state = PS_DIGIT;
          end
        end
        PS_DIGIT: begin
          if (b > CH_ZERO && b < CH_NINE) begin
            dur_latched = 5'((b - CH_ZERO) * 8'd3);
            if (cmd_count != 8'hFF) cmd_count = cmd_count + 8'd1;
            cmd_state = PS_IDLE;
            r.command_done = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // The marker is judged on the two bytes before this one.
    if (last2_byte == CH_R && last_byte == CH_EQ) capture_on = 1'b1;
    if (capture_on && stored_count < ADDR_LEN) begin
      r.addr_written = 1'b1;
      r.addr_slot = 4'(stored_count);
      stored_count++;
    end
    last2_byte = last_byte;
    last_byte = b;
    r.direction_code = dir_latched;
    r.duration_units = dur_latched;
    r.command_count = cmd_count;
    r.capture_active = capture_on;
    return r;
  endfunction

  // Called in the time step of the previous acceptance, so a back-to-back item keeps
  // valid high without lowering it first.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (in_tready !== 1'b1);
    echo_status_q.push_back(parse_byte(b));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_frame(input logic [7:0] letter, input logic [7:0] digit);
    send_byte(CH_START);
    for (int k = 1; k <= 4; k++) send_byte(CH_ZERO + 8'(k));
    send_byte(letter);
    send_byte(digit);
  endtask

  function automatic logic [7:0] any_letter();
    return DIR_LETTERS[$urandom_range(0, 12) * 8 +: 8];
  endfunction

  function automatic logic [7:0] any_digit();
    return CH_ZERO + 8'($urandom_range(1, 8));
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (echo_status_q.size() != 0);
  endtask

  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame("F", "1");
    // Restart in mid-frame, stray bytes inside the frame, a non-letter and both bad digits.
    send_text("^1x2^1234qZ098");
  endtask

  task automatic test_random();
    logic [7:0] frame [7];
    int kind;
    int stop_at;
    int len;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        tx_idle_on = 1'($urandom_range(0, 1));
        rx_idle_on = 1'($urandom_range(0, 1));
      end
      if (kind < 2) drain();
      frame[0] = CH_START;
      for (int k = 1; k <= 4; k++) frame[k] = CH_ZERO + 8'(k);
      frame[5] = any_letter();
      frame[6] = any_digit();
      len = 7;
      if (kind >= 90) begin
        frame[0] = 8'($urandom_range(0, 255));
        len = 1;
      end else if (kind >= 80) begin
        len = $urandom_range(1, 6);
      end else if (kind >= 62) begin
        frame[$urandom_range(1, 6)] = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < len; i++) send_byte(frame[i]);
    end
  endtask

  // The receiver stops for a long stretch while the sender keeps offering items.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_long <= 1'b1;
    repeat (6) send_frame(any_letter(), any_digit());
    tx_idle_on = 1'b1;
    drain();
    send_frame(any_letter(), any_digit());
  endtask

  task automatic test_address_capture();
    send_text("r=");
    send_frame(any_letter(), any_digit());
    // Enough bytes to fill the store and run past it.
    repeat (13) send_byte(8'($urandom_range(0, 255)));
    send_text("r=ab");
  endtask

  initial begin : receiver
    int wait_cycles;
    forever begin
      wait_cycles = rx_idle_on ? $urandom_range(0, 12) : 0;
      if (hold_long === 1'b1) begin
        wait_cycles = LONG_HOLD;
        hold_long <= 1'b0;
      end
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  task automatic flag_mismatch(input string what, input drive_status_t want,
                               input drive_status_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0d (%s) at %0t", mismatches, what, $realtime);
      $display("  expected echo=%h done=%b dir=%0d dur=%0d cnt=%0d wr=%b slot=%0d act=%b",
               want.echo_byte, want.command_done, want.direction_code, want.duration_units,
               want.command_count, want.addr_written, want.addr_slot, want.capture_active);
      $display("  actual   echo=%h done=%b dir=%0d dur=%0d cnt=%0d wr=%b slot=%0d act=%b",
               got.echo_byte, got.command_done, got.direction_code, got.duration_units,
               got.command_count, got.addr_written, got.addr_slot, got.capture_active);
    end
  endtask

  always @(posedge clk) begin
    drive_status_t got;
    drive_status_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (echo_status_q.size() == 0) begin
        flag_mismatch("no item awaited", '0, got);
      end else begin
        want = echo_status_q.pop_front();
        if (got.echo_byte !== want.echo_byte || got.command_done !== want.command_done ||
            got.direction_code !== want.direction_code ||
            got.duration_units !== want.duration_units ||
            got.command_count !== want.command_count ||
            got.addr_written !== want.addr_written || got.addr_slot !== want.addr_slot ||
            got.capture_active !== want.capture_active)
          flag_mismatch("field differs", want, got);
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d items outstanding",
               QUIET_LIMIT, echo_status_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    test_address_capture();
    drain();
    repeat (4) @(posedge clk);
    $display("covered: %0d bytes sent, %0d results checked, command count %0d at the end",
             items_sent, results_seen, cmd_count);
    $display("covered: %0d address bytes stored, %0d mismatches", stored_count, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* uart_drive_command_parser_top.f */
design/ucp_pkg.sv
design/ucp_ram.sv
design/ucp_parser.sv
design/ucp_capture.sv
design/uart_drive_command_parser_top.sv
design/ucp_checker.sv
tb/sv/tb.sv
